FILE: hdl/ftf_pkg.sv
// ftf_pkg: shared widths, codes, command/status structs and format helpers
// for the fraction-to-float converter. No dependencies; compile first.
package ftf_pkg;

  localparam int unsigned NUM_W      = 64;  // numerator / magnitude
  localparam int unsigned DEN_W      = 63;  // denominator and remainder
  localparam int unsigned WORD_W     = 64;  // each half of the packed word
  localparam int unsigned SCALE_W    = 9;   // err_scale
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned MANT_MAX   = 112; // widest mantissa
  localparam int unsigned LEN_W      = 7;   // holds 0..112
  localparam int unsigned POS_W      = 9;   // bit position 63 down to -176
  localparam int unsigned EXP_W      = 7;   // unbiased exponent -63..63
  localparam int unsigned BEXP_W     = 15;  // widest biased exponent

  localparam logic [LEN_W-1:0] MANT_W32  = 7'd23;
  localparam logic [LEN_W-1:0] MANT_W64  = 7'd52;
  localparam logic [LEN_W-1:0] MANT_W128 = 7'd112;

  localparam logic [BEXP_W-1:0] BIAS32  = 15'd127;
  localparam logic [BEXP_W-1:0] BIAS64  = 15'd1023;
  localparam logic [BEXP_W-1:0] BIAS128 = 15'd16383;

  typedef enum logic [1:0] {
    FMT_BINARY32  = 2'd0,
    FMT_BINARY64  = 2'd1,
    FMT_BINARY128 = 2'd2
  } fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DENOMINATOR   = 2'd0,
    REG_FORMAT_SELECT = 2'd1
  } reg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic start;     // load a new request
    logic step;      // one restoring-division step
    logic load_out;  // move the finished result into the output register
  } ftf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic zero_in;   // incoming numerator is zero
    logic done;      // mantissa complete and integer bits consumed
  } ftf_sts_t;

  function automatic logic [LEN_W-1:0] mant_width(input logic [1:0] fmt);
    logic [LEN_W-1:0] w;
    case (fmt)
      FMT_BINARY32: w = MANT_W32;
      FMT_BINARY64: w = MANT_W64;
      default:      w = MANT_W128;
    endcase
    return w;
  endfunction

  function automatic logic [BEXP_W-1:0] bias_of(input logic [1:0] fmt);
    logic [BEXP_W-1:0] b;
    case (fmt)
      FMT_BINARY32: b = BIAS32;
      FMT_BINARY64: b = BIAS64;
      default:      b = BIAS128;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/ftf_intf.sv
// ftf_intf: valid/ready channel interfaces for the converter (input request,
// result, configuration write). Depends on ftf_pkg.
interface ftf_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [ftf_pkg::NUM_W-1:0] numerator;
  modport source (output valid, output numerator, input ready);
  modport sink   (input valid, input numerator, output ready);
endinterface

interface ftf_out_if;
  logic                               valid;
  logic                               ready;
  logic [ftf_pkg::WORD_W-1:0]         word_high;
  logic [ftf_pkg::WORD_W-1:0]         word_low;
  logic [ftf_pkg::DEN_W-1:0]          rem_out;
  logic signed [ftf_pkg::SCALE_W-1:0] err_scale;
  modport source (output valid, output word_high, output word_low, output rem_out,
                  output err_scale, input ready);
  modport sink   (input valid, input word_high, input word_low, input rem_out,
                  input err_scale, output ready);
endinterface

interface ftf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ftf_pkg::CFG_IDX_W-1:0]  index;
  logic [ftf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/ftf_datapath.sv
// ftf_datapath: config registers, restoring divider, mantissa shifter,
// result packing and output register. Depends on ftf_pkg.
module ftf_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ftf_pkg::ftf_cmd_t                  cmd_i,
  output ftf_pkg::ftf_sts_t                  sts_o,
  input  logic signed [ftf_pkg::NUM_W-1:0]   numerator_i,
  input  logic                               cfg_we_i,
  input  logic [ftf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ftf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic [ftf_pkg::WORD_W-1:0]         word_high_o,
  output logic [ftf_pkg::WORD_W-1:0]         word_low_o,
  output logic [ftf_pkg::DEN_W-1:0]          rem_out_o,
  output logic signed [ftf_pkg::SCALE_W-1:0] err_scale_o
);

  // configuration
  logic [ftf_pkg::DEN_W-1:0] den_q;
  logic [1:0]                fmt_q;

  // working registers
  logic                         zero_q, zero_d;
  logic                         sign_q, sign_d;
  logic [ftf_pkg::NUM_W-1:0]    mag_q, mag_d;
  logic [ftf_pkg::DEN_W-1:0]    rem_q, rem_d;
  logic [ftf_pkg::MANT_MAX-1:0] mant_q, mant_d;
  logic [ftf_pkg::LEN_W-1:0]    len_q, len_d;
  logic signed [ftf_pkg::POS_W-1:0] pos_q, pos_d;
  logic signed [ftf_pkg::EXP_W-1:0] exp_q, exp_d;
  logic                         seen_q, seen_d;

  // output register
  logic [ftf_pkg::WORD_W-1:0]         word_high_q, word_low_q;
  logic [ftf_pkg::DEN_W-1:0]          rem_out_q;
  logic signed [ftf_pkg::SCALE_W-1:0] err_scale_q;

  logic [ftf_pkg::NUM_W-1:0]    trial, diff, den_ext, mag_in;
  logic                         qbit;
  logic [ftf_pkg::LEN_W-1:0]    mant_w;
  logic [ftf_pkg::BEXP_W-1:0]   bexp;
  logic [ftf_pkg::WORD_W-1:0]   res_high, res_low;
  logic signed [ftf_pkg::SCALE_W-1:0] res_scale;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      den_q <= ftf_pkg::DEN_W'(1);
      fmt_q <= ftf_pkg::FMT_BINARY32;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ftf_pkg::REG_DENOMINATOR: begin
          // zero divisor behaves as one
          den_q <= (cfg_data_i[ftf_pkg::DEN_W-1:0] == '0) ? ftf_pkg::DEN_W'(1)
                                                          : cfg_data_i[ftf_pkg::DEN_W-1:0];
        end
        ftf_pkg::REG_FORMAT_SELECT: fmt_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign mant_w  = ftf_pkg::mant_width(fmt_q);
  assign mag_in  = numerator_i[ftf_pkg::NUM_W-1] ? (~numerator_i + 1'b1) : numerator_i;

  // one restoring step: bring in the next magnitude bit (zeros once exhausted)
  assign den_ext = {1'b0, den_q};
  assign trial   = {rem_q, mag_q[ftf_pkg::NUM_W-1]};
  assign diff    = trial - den_ext;
  assign qbit    = (trial >= den_ext);

  always_comb begin
    zero_d = zero_q;
    sign_d = sign_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    mant_d = mant_q;
    len_d  = len_q;
    pos_d  = pos_q;
    exp_d  = exp_q;
    seen_d = seen_q;
    if (cmd_i.start) begin
      zero_d = (numerator_i == '0);
      sign_d = numerator_i[ftf_pkg::NUM_W-1];
      mag_d  = mag_in;
      rem_d  = '0;
      mant_d = '0;
      len_d  = '0;
      pos_d  = ftf_pkg::POS_W'(ftf_pkg::NUM_W - 1);
      exp_d  = '0;
      seen_d = 1'b0;
    end else if (cmd_i.step) begin
      mag_d = {mag_q[ftf_pkg::NUM_W-2:0], 1'b0};
      rem_d = qbit ? diff[ftf_pkg::DEN_W-1:0] : trial[ftf_pkg::DEN_W-1:0];
      pos_d = pos_q - 1'b1;
      if (!seen_q && qbit) begin
        // leading one: sets the exponent, not stored in the mantissa
        seen_d = 1'b1;
        exp_d  = pos_q[ftf_pkg::EXP_W-1:0];
      end
      if (seen_q && (len_q < mant_w)) begin
        mant_d = {mant_q[ftf_pkg::MANT_MAX-2:0], qbit};
        len_d  = len_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    sign_q <= sign_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    mant_q <= mant_d;
    len_q  <= len_d;
    pos_q  <= pos_d;
    exp_q  <= exp_d;
    seen_q <= seen_d;
  end

  // integer bits all consumed (position negative) and mantissa full
  assign sts_o.done    = pos_q[ftf_pkg::POS_W-1] && seen_q && (len_q == mant_w);
  assign sts_o.zero_in = (numerator_i == '0);

  // packing
  assign bexp = ftf_pkg::BEXP_W'(exp_q) + ftf_pkg::bias_of(fmt_q);
  assign res_scale = ftf_pkg::SCALE_W'(exp_q) - $signed({2'b00, mant_w});

  always_comb begin
    res_high = '0;
    res_low  = '0;
    case (fmt_q)
      ftf_pkg::FMT_BINARY32: begin
        res_low = {32'd0, sign_q, bexp[7:0], mant_q[22:0]};
      end
      ftf_pkg::FMT_BINARY64: begin
        res_low = {sign_q, bexp[10:0], mant_q[51:0]};
      end
      default: begin
        res_high = {sign_q, bexp, mant_q[111:64]};
        res_low  = mant_q[63:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      word_high_q <= zero_q ? '0 : res_high;
      word_low_q  <= zero_q ? '0 : res_low;
      rem_out_q   <= zero_q ? '0 : rem_q;
      err_scale_q <= zero_q ? '0 : res_scale;
    end
  end

  assign word_high_o = word_high_q;
  assign word_low_o  = word_low_q;
  assign rem_out_o   = rem_out_q;
  assign err_scale_o = err_scale_q;

endmodule

FILE: hdl/ftf_ctrl.sv
// ftf_ctrl: sequencing state machine and output-valid flag for the
// converter. Depends on ftf_pkg.
module ftf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ftf_pkg::ftf_sts_t sts_i,
  output ftf_pkg::ftf_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.zero_in ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.done) state_d = ST_FINISH;
        else            cmd_o.step = 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/fraction_to_float_converter_top.sv
// fraction_to_float_converter_top: top level of the converter; joins the
// controller and datapath to the channels. Depends on ftf_pkg, ftf_intf,
// ftf_ctrl and ftf_datapath.
//
// Converts numerator / denominator into a truncated binary32, binary64 or
// binary128 word (format and denominator set by config writes, which the
// user must have made only while idle; the block does not enforce this).
// One request at a time: the single restoring-division step unit steps
// through the 64 magnitude bits, then one fraction step per missing mantissa
// bit (more below one, one per leading zero), checks done and hands off to
// the output register. A zero numerator skips the steps. As the result sits
// in an output register, a new request is taken while the previous result
// still waits. rem_out is the remainder after the last step; unless the
// mantissa fills within the integer bits, the truncation error equals
// rem_out / denominator * 2^err_scale. Config writes always complete at once.
module fraction_to_float_converter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ftf_in_if.sink     in_if_i,
  ftf_out_if.source  out_if_o,
  ftf_cfg_if.sink    cfg_if_i
);

  ftf_pkg::ftf_cmd_t cmd;
  ftf_pkg::ftf_sts_t sts;

  // config registers take a write every cycle
  assign cfg_if_i.ready = 1'b1;

  ftf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if_i.valid),
    .in_ready_o  (in_if_i.ready),
    .out_valid_o (out_if_o.valid),
    .out_ready_i (out_if_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ftf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .numerator_i (in_if_i.numerator),
    .cfg_we_i    (cfg_if_i.valid),
    .cfg_index_i (cfg_if_i.index),
    .cfg_data_i  (cfg_if_i.data),
    .word_high_o (out_if_o.word_high),
    .word_low_o  (out_if_o.word_low),
    .rem_out_o   (out_if_o.rem_out),
    .err_scale_o (out_if_o.err_scale)
  );

  // one request in flight: ready drops right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if_i.valid && in_if_i.ready) |=> !in_if_i.ready)
    else $error("ready stayed high after a request was accepted");

  // an all-zero word only comes from a zero numerator, with no error terms
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if_o.valid && (out_if_o.word_high == '0) && (out_if_o.word_low == '0))
      |-> ((out_if_o.rem_out == '0) && (out_if_o.err_scale == '0)))
    else $error("zero word with nonzero remainder or scale");

  // error scale stays within the reachable exponent range; the top end is a
  // 2^63 magnitude over a unit denominator in binary32
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if_o.valid |-> ((out_if_o.err_scale >= -9'sd175) &&
                        (out_if_o.err_scale <= 9'sd40)))
    else $error("err_scale out of range");

endmodule

FILE: verif/ftf_result_checker.sv
`timescale 1ns / 1ps
// ftf_result_checker: watches the request, result and config channels of the
// converter, predicts each result and compares it. Depends on ftf_pkg, ftf_intf.
module ftf_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ftf_in_if           in_mon_i,
  ftf_out_if          out_mon_i,
  ftf_cfg_if          cfg_mon_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned words_in_flight_o
);
  import ftf_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0]          numerator;
    logic [WORD_W-1:0]         word_high;
    logic [WORD_W-1:0]         word_low;
    logic [DEN_W-1:0]          rem_out;
    logic signed [SCALE_W-1:0] err_scale;
  } float_word_t;

  logic [DEN_W-1:0] denominator_q;
  logic [1:0]       format_q;
  float_word_t      pending_words[$];

  // Truncating conversion of num / den into the packed word of the format.
  function automatic float_word_t convert_fraction(input logic [NUM_W-1:0] num,
                                                   input logic [DEN_W-1:0] den_reg,
                                                   input logic [1:0] fmt);
    float_word_t  r;
    logic [63:0]  den, mag, ip, rem, be;
    logic [127:0] mant;
    logic         sign;
    int           mant_w, exp_w, bias, expo, len, hb, i;
    r = '0;
    r.numerator = num;
    if (num == '0) return r;
    case (fmt)
      FMT_BINARY32: begin
        mant_w = MANT_W32; exp_w = 8; bias = BIAS32;
      end
      FMT_BINARY64: begin
        mant_w = MANT_W64; exp_w = 11; bias = BIAS64;
      end
      default: begin
        mant_w = MANT_W128; exp_w = 15; bias = BIAS128;
      end
    endcase
    den  = (den_reg == '0) ? 64'd1 : {1'b0, den_reg};
    sign = num[63];
    mag  = sign ? (~num + 64'd1) : num;
    ip   = mag / den;
    rem  = mag % den;
    mant = '0;
    len  = 0;
    expo = 0;
    if (ip != '0) begin
      hb = 0;
      for (i = 0; i < 64; i++) if (ip[i]) hb = i;
      expo = hb;
      // integer bits under the leading one; surplus ones are dropped
      for (i = hb - 1; i >= 0; i--) begin
        if (len < mant_w) begin
          mant = {mant[126:0], ip[i]};
          len++;
        end
      end
    end else begin
      // below one: double until the value reaches one
      while (rem < den) begin
        rem = rem << 1;
        expo--;
        if (rem == '0) break;
      end
      if (rem >= den) rem = rem - den;
    end
    while (len < mant_w) begin
      rem = rem << 1;
      if (rem >= den) begin
        rem  = rem - den;
        mant = {mant[126:0], 1'b1};
      end else begin
        mant = {mant[126:0], 1'b0};
      end
      len++;
    end
    be = 64'(expo + bias) & ((64'd1 << exp_w) - 64'd1);
    if (mant_w == MANT_W128) begin
      r.word_high = {sign, be[14:0], mant[111:64]};
      r.word_low  = mant[63:0];
    end else begin
      r.word_low = ({63'd0, sign} << (exp_w + mant_w)) | (be << mant_w) | mant[63:0];
    end
    r.rem_out   = rem[DEN_W-1:0];
    r.err_scale = SCALE_W'(expo - mant_w);
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] num,
                               input logic [63:0] want, input logic [63:0] seen);
    if (mismatch_cnt_o < 10)
      $display("mismatch on %s, numerator %h: expected %h, got %h", field, num, want, seen);
    mismatch_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    float_word_t want;
    float_word_t seen;
    if (!rst_ni) begin
      denominator_q  = 1;
      format_q       = FMT_BINARY32;
      mismatch_cnt_o = 0;
      pending_words.delete();
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        if (cfg_mon_i.index == REG_DENOMINATOR)
          denominator_q = cfg_mon_i.data[DEN_W-1:0];
        else if (cfg_mon_i.index == REG_FORMAT_SELECT)
          format_q = cfg_mon_i.data[1:0];
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        seen = '0;
        seen.word_high = out_mon_i.word_high;
        seen.word_low  = out_mon_i.word_low;
        seen.rem_out   = out_mon_i.rem_out;
        seen.err_scale = out_mon_i.err_scale;
        if (pending_words.size() == 0) begin
          if (mismatch_cnt_o < 10)
            $display("result %h_%h arrived with no request pending",
                     seen.word_high, seen.word_low);
          mismatch_cnt_o++;
        end else begin
          want = pending_words.pop_front();
          if (seen.word_high !== want.word_high)
            note_mismatch("word_high", want.numerator, want.word_high, seen.word_high);
          if (seen.word_low !== want.word_low)
            note_mismatch("word_low", want.numerator, want.word_low, seen.word_low);
          if (seen.rem_out !== want.rem_out)
            note_mismatch("rem_out", want.numerator, 64'(want.rem_out), 64'(seen.rem_out));
          if (seen.err_scale !== want.err_scale)
            note_mismatch("err_scale", want.numerator, 64'(want.err_scale),
                          64'(seen.err_scale));
        end
      end
      if (in_mon_i.valid && in_mon_i.ready)
        pending_words.push_back(convert_fraction(in_mon_i.numerator, denominator_q, format_q));
    end
    words_in_flight_o = pending_words.size();
  end

endmodule

FILE: verif/tb_fraction_to_float_converter_top.sv
`timescale 1ns / 1ps
// tb_fraction_to_float_converter_top: drives requests and config writes into the
// converter and gives the verdict. Depends on ftf_pkg, ftf_intf, ftf_result_checker.
module tb_fraction_to_float_converter_top;
  import ftf_pkg::*;

  // config indexes that map to no register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  // format code 3 behaves as binary128
  localparam logic [1:0]           FMT_SPARE   = 2'd3;
  localparam logic [DEN_W-1:0]     DEN_MAX     = {DEN_W{1'b1}};
  localparam int                   RAND_PHASES = 8;
  localparam int                   PHASE_ITEMS = 125;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatch_cnt;
  int unsigned words_in_flight;
  int          burst_left;
  logic [63:0] directed_q[$];

  ftf_in_if  in_ch();
  ftf_out_if out_ch();
  ftf_cfg_if cfg_ch();

  fraction_to_float_converter_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if_i  (in_ch),
    .out_if_o (out_ch),
    .cfg_if_i (cfg_ch)
  );

  ftf_result_checker checker_inst (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_mon_i          (in_ch),
    .out_mon_i         (out_ch),
    .cfg_mon_i         (cfg_ch),
    .mismatch_cnt_o    (mismatch_cnt),
    .words_in_flight_o (words_in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a correct run needs well under 3 ms (about 1050 requests, each
  // busy for its division steps, plus sender gaps and result-side stalls).
  initial begin
    #15_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Mix of magnitudes: zero, extremes, full-width noise, and values cut to a
  // random bit length so the integer part ranges from empty to 63 bits.
  function automatic logic [63:0] random_numerator();
    logic [63:0] v;
    int          w;
    int          sel;
    sel = $urandom_range(0, 9);
    v   = {$urandom, $urandom};
    if (sel == 0) begin
      v = '0;
    end else if (sel == 1) begin
      case ($urandom_range(0, 3))
        0:       v = 64'h7FFF_FFFF_FFFF_FFFF;
        1:       v = 64'h8000_0000_0000_0000;
        2:       v = 64'h8000_0000_0000_0001;
        default: v = 64'd1;
      endcase
    end else if (sel >= 4) begin
      w = $urandom_range(1, 63);
      v = v & ((64'd1 << w) - 64'd1);
      if ($urandom_range(0, 1)) v = ~v + 64'd1;
    end
    return v;
  endfunction

  // Config request; valid is left high so back-to-back writes need no toggle.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
  endtask

  // Conversion request. The sender runs in bursts; a gap, which may be empty, follows each burst.
  task automatic push_numerator(input logic [63:0] n);
    int gap;
    in_ch.valid     = 1'b1;
    in_ch.numerator = n;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // One setting of the registers: wait for idle, write, then queued directed
  // requests followed by random ones. Upper data bits are junk on purpose.
  task automatic run_phase(input logic [DEN_W-1:0] den, input logic [1:0] fmt,
                           input int n_random);
    while (words_in_flight != 0) @(negedge clk_i);
    cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
    cfg_write(REG_DENOMINATOR, {1'($urandom_range(0, 1)), den});
    cfg_write(REG_FORMAT_SELECT, {$urandom, 30'($urandom), fmt});
    cfg_ch.valid = 1'b0;
    foreach (directed_q[k]) push_numerator(directed_q[k]);
    directed_q.delete();
    repeat (n_random) push_numerator(random_numerator());
    in_ch.valid = 1'b0;
  endtask

  // Result side stalls on its own pattern: open stretches, coin flips,
  // mostly-ready stretches and long holds.
  initial begin : ready_pattern
    int mode;
    int span;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 200);
      case (mode)
        0: repeat (span) begin
          @(negedge clk_i);
          out_ch.ready = 1'b1;
        end
        1: repeat (span) begin
          @(negedge clk_i);
          out_ch.ready = 1'($urandom_range(0, 1));
        end
        2: repeat (span) begin
          @(negedge clk_i);
          out_ch.ready = ($urandom_range(0, 7) != 0);
        end
        default: begin
          @(negedge clk_i);
          out_ch.ready = 1'b0;
          repeat ($urandom_range(1, 48)) @(negedge clk_i);
          out_ch.ready = 1'b1;
        end
      endcase
    end
  end

  initial begin : stimulus
    logic [63:0] d;
    int          w;
    int          p;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.numerator = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_DENOMINATOR;
    cfg_ch.data     = '0;
    burst_left      = $urandom_range(1, 16);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Denominator one, binary32: zero, unit values, both signed extremes, a
    // value filling the mantissa exactly and one whose integer part overflows it.
    directed_q = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 64'd3,
                   64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                   64'h8000_0000_0000_0001, 64'h0000_0000_00FF_FFFF,
                   64'h0000_0001_0000_0000};
    run_phase(63'd1, FMT_BINARY32, 0);

    // Largest denominator, binary128: values far below one (deepest
    // normalization), exactly one, and the unsigned 2^63 magnitude.
    directed_q = '{64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                   64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'd12345};
    run_phase(DEN_MAX, FMT_BINARY128, 0);

    // Repeating fraction with a nonzero remainder, binary64.
    directed_q = '{64'd1, 64'hFFFF_FFFF_FFFF_FFFE, 64'd3, 64'd10,
                   64'h7FFF_FFFF_FFFF_FFFF};
    run_phase(63'd3, FMT_BINARY64, 0);

    // Zero denominator acts as one; format code 3 acts as binary128.
    directed_q = '{64'd0, 64'd5, 64'hFFFF_FFFF_FFFF_FFF9};
    run_phase('0, FMT_SPARE, 0);

    for (p = 0; p < RAND_PHASES; p++) begin
      w = $urandom_range(1, DEN_W);
      d = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
      // pin a couple of phases to the denominator extremes
      if (p == 2) d = 64'(DEN_MAX);
      if (p == 5) d = 64'd1;
      run_phase(d[DEN_W-1:0], 2'($urandom_range(0, 3)), PHASE_ITEMS);
    end

    // drain, then leave room for any stray result to show up
    while (words_in_flight != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (mismatch_cnt == 0 && words_in_flight == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
